// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the validator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

// ===== hw/rtl/hlv_pkg.sv =====
// Types, constants and functions of the hostname label validator.
package hlv_pkg;

    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned LABEL_LEN_W   = 6;
    localparam int unsigned NAME_LEN_W    = 8;
    localparam int unsigned LABEL_CNT_W   = 7;
    localparam int unsigned TOTAL_CNT_W   = 9;
    localparam int unsigned APB_DATA_W    = 32;
    localparam int unsigned APB_ADDR_W    = 3;

    localparam logic [LABEL_CNT_W-1:0] LABEL_SAT = 7'd64;
    localparam logic [TOTAL_CNT_W-1:0] TOTAL_SAT = 9'd256;

    localparam logic [LABEL_LEN_W-1:0] MAX_LABEL_RESET = 6'd63;
    localparam logic [NAME_LEN_W-1:0]  MAX_NAME_RESET  = 8'd255;

    localparam logic [BYTE_W-1:0] CHAR_DOT    = 8'h2E;
    localparam logic [BYTE_W-1:0] CHAR_HYPHEN = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_UNDER  = 8'h5F;

    typedef enum logic {
        REG_MAX_LABEL = 1'b0,
        REG_MAX_NAME  = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [LABEL_LEN_W-1:0] max_label_length;
        logic [NAME_LEN_W-1:0]  max_name_length;
    } t_cfg;

    function automatic logic byte_allowed(input logic [BYTE_W-1:0] b);
        logic ok;
        ok = (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]})
            || (b == CHAR_HYPHEN) || (b == CHAR_UNDER);
        return ok;
    endfunction

endpackage

// ===== hw/rtl/hlv_if.sv =====
// Valid/ready channel interfaces for name bytes and results.
interface hlv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] name_byte;
    logic       final_byte;

    modport source(output valid, output name_byte, output final_byte, input ready);
    modport sink(input valid, input name_byte, input final_byte, output ready);
endinterface

interface hlv_out_if;
    logic valid;
    logic ready;
    logic name_valid;

    modport source(output valid, output name_valid, input ready);
    modport sink(input valid, input name_valid, output ready);
endinterface

// ===== hw/rtl/hostname_label_validator_top.sv =====
// Top level of the hostname label validator: byte checks, name state, result register.
// Checks a hostname streamed one byte per item and gives one result item, on the
// final byte, that is 1 when the name passed every syntax rule. One byte is taken
// every cycle unless a final byte is held in the input register. A result is offered
// after its final byte is accepted: the byte is checked out of the input register
// and the verdict lands in the result register. A result waiting on a stalled output
// does not stop non-final bytes from being taken; a final byte waits in the input
// register until the result register frees up. Limits are written through the APB
// port at byte addresses 0 (label) and 4 (name).
module hostname_label_validator_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    hlv_in_if.sink                            i_in,
    hlv_out_if.source                         o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hlv_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [hlv_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [hlv_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import hlv_pkg::*;
    `include "assert_macros.svh"

    t_cfg w_cfg;

    hlv_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_s1_byte;
    logic              r_s1_final;

    logic [TOTAL_CNT_W-1:0] r_total;
    logic [LABEL_CNT_W-1:0] r_label;
    logic                   r_hyphen;
    logic                   r_failed;

    logic r_out_valid;
    logic r_out_name_valid;

    logic                   w_out_free;
    logic                   w_s1_go;
    logic                   w_in_acc;
    logic                   w_is_dot;
    logic                   w_is_hyphen;
    logic [TOTAL_CNT_W-1:0] n_total;
    logic [LABEL_CNT_W-1:0] n_label;
    logic                   n_hyphen;
    logic                   n_failed;
    logic                   w_fail_final;
    logic                   w_final_go;
    logic                   w_name_clear;
    logic                   w_counts_ok;

    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_s1_go     = r_s1_valid && (!r_s1_final || w_out_free);
    assign i_in.ready  = !r_s1_valid || w_s1_go;
    assign w_in_acc    = i_in.valid && i_in.ready;

    assign w_is_dot    = (r_s1_byte == CHAR_DOT);
    assign w_is_hyphen = (r_s1_byte == CHAR_HYPHEN);

    always_comb begin
        n_total  = (r_total < TOTAL_SAT) ? r_total + 1'b1 : r_total;
        n_failed = r_failed;
        if (w_is_dot) begin
            if ((r_label == '0) || r_hyphen) begin
                n_failed = 1'b1;
            end
            n_label  = '0;
            n_hyphen = 1'b0;
        end else begin
            if ((r_label == '0) && w_is_hyphen) begin
                n_failed = 1'b1;
            end
            if (!byte_allowed(r_s1_byte)) begin
                n_failed = 1'b1;
            end
            n_label = (r_label < LABEL_SAT) ? r_label + 1'b1 : r_label;
            if (n_label > {1'b0, w_cfg.max_label_length}) begin
                n_failed = 1'b1;
            end
            n_hyphen = w_is_hyphen;
        end
        w_fail_final = n_failed || n_hyphen
            || (n_total > {1'b0, w_cfg.max_name_length});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_byte  <= i_in.name_byte;
            r_s1_final <= i_in.final_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= '0;
            r_label  <= '0;
            r_hyphen <= 1'b0;
            r_failed <= 1'b0;
        end else if (w_s1_go) begin
            if (r_s1_final) begin
                r_total  <= '0;
                r_label  <= '0;
                r_hyphen <= 1'b0;
                r_failed <= 1'b0;
            end else begin
                r_total  <= n_total;
                r_label  <= n_label;
                r_hyphen <= n_hyphen;
                r_failed <= n_failed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_go && r_s1_final) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_go && r_s1_final) begin
            r_out_name_valid <= !w_fail_final;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.name_valid = r_out_name_valid;

    assign w_final_go   = w_s1_go && r_s1_final;
    assign w_name_clear = (r_total == '0) && (r_label == '0) && !r_failed && !r_hyphen;
    assign w_counts_ok  = (r_label <= LABEL_SAT) && (r_total <= TOTAL_SAT)
        && ({2'b00, r_label} <= r_total);

    `ASSERT_NEXT(a_clear_after_final, i_clk, i_rst_n, w_final_go, w_name_clear)
    `ASSERT_SAME(a_label_within_total, i_clk, i_rst_n, 1'b1, w_counts_ok)
    `ASSERT_SAME(a_final_waits_for_output, i_clk, i_rst_n, w_final_go, w_out_free)

endmodule

// ===== hw/rtl/hlv_cfg_regs.sv =====
// APB configuration registers for the label and name length limits.
module hlv_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hlv_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [hlv_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [hlv_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output hlv_pkg::t_cfg                     o_cfg
);
    import hlv_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[2]);
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_label_length <= MAX_LABEL_RESET;
            r_cfg.max_name_length  <= MAX_NAME_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_MAX_LABEL: r_cfg.max_label_length <= pwdata[LABEL_LEN_W-1:0];
                REG_MAX_NAME:  r_cfg.max_name_length  <= pwdata[NAME_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_MAX_LABEL:
                prdata = {{(APB_DATA_W-LABEL_LEN_W){1'b0}}, r_cfg.max_label_length};
            REG_MAX_NAME:
                prdata = {{(APB_DATA_W-NAME_LEN_W){1'b0}}, r_cfg.max_name_length};
            default: prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
